// File: rtl/mpeg_audio_header_decode_core_assert.svh
// Assertion macros for the MPEG audio header decoder.
// Included by modules that check their own pipeline; expects clk and rst_n in scope.
`ifndef MPEG_AUDIO_HEADER_DECODE_CORE_ASSERT_SVH
`define MPEG_AUDIO_HEADER_DECODE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MAHD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MAHD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mahd_pkg.sv
// Package for the MPEG audio header decoder: beat types, status codes and lookup tables.
// Depends on nothing; used by mpeg_audio_header_decode_core.
package mahd_pkg;

  typedef struct packed {
    logic [31:0] header_word;
    logic [2:0]  bytes_available;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        frame_valid;
    logic [8:0]  bit_rate_kbps;
    logic [15:0] sample_rate_hz;
    logic [11:0] frame_bytes;
    logic [1:0]  channel_count;
    logic [16:0] duration_us;
  } out_beat_t;

  // Frame size is floor(br * k / 441) or br * k, then shifted right by shift.
  typedef struct packed {
    logic [12:0] k;
    logic        div441;
    logic [2:0]  shift;
  } coef_t;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_BAD   = 2'd2;
  localparam logic [1:0] STAT_RATE  = 2'd3;

  localparam logic [1:0] VER_25 = 2'd0;
  localparam logic [1:0] VER_2  = 2'd2;
  localparam logic [1:0] VER_1  = 2'd3;

  localparam logic [1:0] LAYER_NONE = 2'd0;
  localparam logic [1:0] LAYER_III  = 2'd1;
  localparam logic [1:0] LAYER_II   = 2'd2;
  localparam logic [1:0] LAYER_I    = 2'd3;

  localparam logic [1:0] MODE_MONO = 2'd3;

  localparam logic [2:0] MIN_BYTES = 3'd4;

  // Reciprocal of 441 at 2^32, rounded up; exact for products below 2^22.
  localparam int unsigned RECIP_SHIFT = 32;
  localparam logic [23:0] RECIP_441   = 24'd9739155;

  // Index order: [MPEG-1][layer - 1][bitrate index]; layer rows are III, II, I.
  localparam logic [8:0] BR_TAB [0:1][0:2][0:15] = '{
    '{
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0}
    }
  };

  function automatic logic [15:0] sr_lookup(input logic [1:0] ver, input logic [1:0] fidx);
    logic [15:0] base;
    logic [15:0] sr;
    unique case (fidx)
      2'd0:    base = 16'd44100;
      2'd1:    base = 16'd48000;
      2'd2:    base = 16'd32000;
      default: base = 16'd0;
    endcase
    unique case (ver)
      VER_1:   sr = base;
      VER_2:   sr = base >> 1;
      VER_25:  sr = base >> 2;
      default: sr = 16'd0;
    endcase
    return sr;
  endfunction

  function automatic coef_t coef_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                        input logic [1:0] fidx);
    coef_t       c;
    logic [12:0] base;
    logic [1:0]  vshift;
    logic        half;
    unique case (ver)
      VER_1:   vshift = 2'd0;
      VER_2:   vshift = 2'd1;
      default: vshift = 2'd2;
    endcase
    half = (lay == LAYER_III) && (ver != VER_1);
    unique case (fidx)
      2'd0:    base = (lay == LAYER_I) ? 13'd120 : 13'd1440;
      2'd1:    base = (lay == LAYER_I) ? 13'd2 : 13'd24;
      2'd2:    base = (lay == LAYER_I) ? 13'd3 : 13'd36;
      default: base = 13'd0;
    endcase
    c.k      = base << vshift;
    c.div441 = (fidx == 2'd0);
    c.shift  = ((fidx == 2'd0) ? 3'd0 : 3'd3) + {2'd0, half};
    return c;
  endfunction

  function automatic logic [16:0] dur_lookup(input logic [1:0] ver, input logic [1:0] lay,
                                             input logic [1:0] fidx);
    logic [16:0] d;
    if (lay == LAYER_I) begin
      unique case (fidx)
        2'd0:    d = 17'd8707;
        2'd1:    d = 17'd8000;
        2'd2:    d = 17'd12000;
        default: d = 17'd0;
      endcase
    end else if ((ver == VER_25) && (lay == LAYER_III)) begin
      unique case (fidx)
        2'd0:    d = 17'd52245;
        2'd1:    d = 17'd48000;
        2'd2:    d = 17'd72000;
        default: d = 17'd0;
      endcase
    end else begin
      unique case (fidx)
        2'd0:    d = 17'd26122;
        2'd1:    d = 17'd24000;
        2'd2:    d = 17'd36000;
        default: d = 17'd0;
      endcase
    end
    return d;
  endfunction

endpackage

// File: rtl/mpeg_audio_header_decode_core.sv
// MPEG audio frame header decoder, four register stages with per-stage valid bits.
// Depends on mahd_pkg and mpeg_audio_header_decode_core_assert.svh.
//
// Channel  Dir  Handshake            Beat
// in       in   in_valid/in_stall    mahd_pkg::in_beat_t
// out      out  out_valid/out_stall  mahd_pkg::out_beat_t
//
// One beat enters per cycle while in_stall is low; each result leaves through the
// stage registers in order: the table decode, the rate product, the multiply by the
// reciprocal of 441 and the output register, one stage each.
// Reset clears every valid bit; payload registers are not reset.
// A stage holds only while the stage after it is full and held, so bubbles are squeezed out.
module mpeg_audio_header_decode_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mahd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mahd_pkg::out_beat_t out_data
);

  `include "mpeg_audio_header_decode_core_assert.svh"

  logic        en1, en2, en3, en_out;

  logic [31:0] hdr;
  logic [1:0]  ver, lay, fidx, mode, lay_idx;
  logic [3:0]  bidx;
  logic        hdr_bad;
  logic [8:0]  br_nxt;
  logic [15:0] sr_nxt;
  logic [1:0]  st1_nxt;

  logic                 v1_r, v2_r, v3_r, out_valid_r;
  logic [1:0]           st1_r, st2_r, st3_r;
  logic [8:0]           br1_r, br2_r, br3_r;
  logic [15:0]          sr1_r, sr2_r, sr3_r;
  mahd_pkg::coef_t      coef1_r, coef2_r, coef3_r;
  logic                 pad1_r, pad2_r, pad3_r;
  logic                 layi1_r, layi2_r, layi3_r;
  logic [1:0]           ch1_r, ch2_r, ch3_r;
  logic [16:0]          dur1_r, dur2_r, dur3_r;
  logic [21:0]          prod2_nxt, prod2_r, prod3_r;
  logic [45:0]          mq3_nxt, mq3_r;
  mahd_pkg::out_beat_t  out_r, out_nxt;

  logic [21:0] quot;
  logic [21:0] raw;
  logic [12:0] fb_sum;
  logic [14:0] fb_full;
  logic [1:0]  st_fin;

  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  // Stage 1: field split, checks and table lookups.
  always_comb begin
    hdr     = in_data.header_word;
    ver     = hdr[20:19];
    lay     = hdr[18:17];
    bidx    = hdr[15:12];
    fidx    = hdr[11:10];
    mode    = hdr[7:6];
    lay_idx = (lay == mahd_pkg::LAYER_NONE) ? 2'd0 : lay - 2'd1;
    hdr_bad = (hdr[31:21] != 11'h7FF) || (hdr[15:10] == 6'h3F) || (hdr[15:12] == 4'd0);
    br_nxt  = mahd_pkg::BR_TAB[ver == mahd_pkg::VER_1][lay_idx][bidx];
    sr_nxt  = mahd_pkg::sr_lookup(ver, fidx);
    priority if (in_data.bytes_available < mahd_pkg::MIN_BYTES) begin
      st1_nxt = mahd_pkg::STAT_SHORT;
    end else if (hdr_bad || (lay == mahd_pkg::LAYER_NONE)) begin
      st1_nxt = mahd_pkg::STAT_BAD;
    end else if ((sr_nxt == 16'd0) || (br_nxt == 9'd0)) begin
      st1_nxt = mahd_pkg::STAT_RATE;
    end else begin
      st1_nxt = mahd_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      st1_r   <= st1_nxt;
      br1_r   <= br_nxt;
      sr1_r   <= sr_nxt;
      coef1_r <= mahd_pkg::coef_lookup(ver, lay, fidx);
      pad1_r  <= hdr[9];
      layi1_r <= (lay == mahd_pkg::LAYER_I);
      ch1_r   <= (mode == mahd_pkg::MODE_MONO) ? 2'd1 : 2'd2;
      dur1_r  <= mahd_pkg::dur_lookup(ver, lay, fidx);
    end
  end

  // Stage 2: bitrate times the per-rate coefficient.
  assign prod2_nxt = 22'(br1_r) * 22'(coef1_r.k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      st2_r   <= st1_r;
      br2_r   <= br1_r;
      sr2_r   <= sr1_r;
      coef2_r <= coef1_r;
      pad2_r  <= pad1_r;
      layi2_r <= layi1_r;
      ch2_r   <= ch1_r;
      dur2_r  <= dur1_r;
      prod2_r <= prod2_nxt;
    end
  end

  // Stage 3: division by 441 as a multiply by its scaled reciprocal.
  assign mq3_nxt = 46'(prod2_r) * 46'(mahd_pkg::RECIP_441);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      st3_r   <= st2_r;
      br3_r   <= br2_r;
      sr3_r   <= sr2_r;
      coef3_r <= coef2_r;
      pad3_r  <= pad2_r;
      layi3_r <= layi2_r;
      ch3_r   <= ch2_r;
      dur3_r  <= dur2_r;
      prod3_r <= prod2_r;
      mq3_r   <= mq3_nxt;
    end
  end

  // Stage 4: final shift, padding slot and result assembly.
  always_comb begin
    quot    = coef3_r.div441 ? {9'd0, mq3_r[mahd_pkg::RECIP_SHIFT + 12:mahd_pkg::RECIP_SHIFT]}
                             : prod3_r;
    raw     = quot >> coef3_r.shift;
    fb_sum  = {1'b0, raw[11:0]} + {12'd0, pad3_r};
    fb_full = layi3_r ? {fb_sum, 2'b00} : {2'b00, fb_sum};
    if (st3_r != mahd_pkg::STAT_OK) begin
      st_fin = st3_r;
    end else if (fb_full == 15'd0) begin
      st_fin = mahd_pkg::STAT_BAD;
    end else begin
      st_fin = mahd_pkg::STAT_OK;
    end
    out_nxt = '0;
    out_nxt.status = st_fin;
    if (st_fin == mahd_pkg::STAT_OK) begin
      out_nxt.frame_valid    = 1'b1;
      out_nxt.bit_rate_kbps  = br3_r;
      out_nxt.sample_rate_hz = sr3_r;
      out_nxt.frame_bytes    = fb_full[11:0];
      out_nxt.channel_count  = ch3_r;
      out_nxt.duration_us    = dur3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MAHD_ASSERT_IMPL(a_fail_clears, out_valid_r && (out_r.status != mahd_pkg::STAT_OK),
    (out_r.frame_bytes == 12'd0) && (out_r.bit_rate_kbps == 9'd0) &&
    (out_r.sample_rate_hz == 16'd0) && (out_r.channel_count == 2'd0) &&
    (out_r.duration_us == 17'd0) && !out_r.frame_valid,
    "failed header beat carries nonzero fields")
  `MAHD_ASSERT_IMPL(a_ok_sane, out_valid_r && out_r.frame_valid,
    (out_r.status == mahd_pkg::STAT_OK) && (out_r.frame_bytes != 12'd0) &&
    (out_r.sample_rate_hz != 16'd0) && (out_r.bit_rate_kbps != 9'd0) &&
    ((out_r.channel_count == 2'd1) || (out_r.channel_count == 2'd2)),
    "good header beat has an empty field")
  `MAHD_ASSERT_NEXT(a_no_spawn, !v3_r && !out_valid_r, !out_valid_r,
    "output beat appeared with an empty pipeline")
  `MAHD_ASSERT_NEXT(a_stage_hold, v3_r && !en3, v3_r,
    "held stage three beat was dropped")

endmodule
